// ===== design/msl_pkg.sv =====
package msl_pkg;

  // Bus address width and number of bus nodes.
  localparam int ADDR_WIDTH = 32;
  localparam int NODE_COUNT = 16;

  // Line states.
  localparam logic [3:0] ST_I  = 4'd0;
  localparam logic [3:0] ST_S  = 4'd1;
  localparam logic [3:0] ST_E  = 4'd2;
  localparam logic [3:0] ST_O  = 4'd3;
  localparam logic [3:0] ST_M  = 4'd4;
  localparam logic [3:0] ST_F  = 4'd5;
  localparam logic [3:0] ST_IM = 4'd6;
  localparam logic [3:0] ST_IS = 4'd7;
  localparam logic [3:0] ST_SM = 4'd8;
  localparam logic [3:0] ST_OM = 4'd9;

  // Request types.
  localparam logic [2:0] RQ_LOAD  = 3'd0;
  localparam logic [2:0] RQ_STORE = 3'd1;
  localparam logic [2:0] RQ_GETS  = 3'd2;
  localparam logic [2:0] RQ_GETM  = 3'd3;
  localparam logic [2:0] RQ_DATA  = 3'd4;

  // Bus request codes.
  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_GETS = 2'd1;
  localparam logic [1:0] BUS_GETM = 2'd2;

  // Mask of the address bits that the bus carries.
  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  // Requester ids wrap into the node range; the table is built at elaboration.
  function automatic logic [15:0][3:0] build_rid_wrap();
    logic [15:0][3:0] tbl;
    for (int i = 0; i < 16; i++) begin
      tbl[i] = 4'(i % NODE_COUNT);
    end
    return tbl;
  endfunction

  localparam logic [15:0][3:0] RID_WRAP = build_rid_wrap();

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] line_addr;
    logic [3:0]  requester_id;
    logic        shared_in;
  } msl_req_t;

  typedef struct packed {
    logic [31:0] addr_out;
    logic        data_to_proc;
    logic [1:0]  bus_request;
    logic        bus_data_send;
    logic [3:0]  data_dest;
    logic        shared_assert;
    logic        miss_pulse;
    logic        silent_upgrade;
    logic        protocol_error;
    logic [3:0]  new_state;
  } msl_rsp_t;

endpackage

// ===== design/msl_next_state.sv =====
module msl_next_state (
  input  logic [3:0]        state,
  input  msl_pkg::msl_req_t req,
  output msl_pkg::msl_rsp_t rsp
);
  import msl_pkg::*;

  logic [3:0] st;
  logic [3:0] st_next;
  logic       to_proc;
  logic [1:0] bus_req;
  logic       send;
  logic       shr;
  logic       miss;
  logic       silent;
  logic       err;
  logic       store;
  logic       getm;

  assign st    = (state > ST_OM) ? ST_I : state;
  assign store = (req.req_type == RQ_STORE);
  assign getm  = (req.req_type == RQ_GETM);

  always_comb begin
    st_next = st;
    to_proc = 1'b0;
    bus_req = BUS_NONE;
    send    = 1'b0;
    shr     = 1'b0;
    miss    = 1'b0;
    silent  = 1'b0;
    err     = 1'b0;
    unique case (req.req_type) inside
      RQ_LOAD, RQ_STORE: begin
        unique case (st) inside
          ST_I: begin
            miss = 1'b1;
            if (store) begin
              bus_req = BUS_GETM;
              st_next = ST_IM;
            end else begin
              bus_req = BUS_GETS;
              st_next = ST_IS;
            end
          end
          ST_S: begin
            if (store) begin
              bus_req = BUS_GETM;
              miss    = 1'b1;
              st_next = ST_SM;
            end else begin
              to_proc = 1'b1;
            end
          end
          ST_E: begin
            to_proc = 1'b1;
            if (store) begin
              silent  = 1'b1;
              st_next = ST_M;
            end
          end
          ST_O, ST_F: begin
            if (store) begin
              bus_req = BUS_GETM;
              miss    = 1'b1;
              st_next = ST_OM;
            end else begin
              to_proc = 1'b1;
            end
          end
          ST_M: begin
            to_proc = 1'b1;
          end
          default: begin
            // A request is already outstanding on the bus.
            err = 1'b1;
          end
        endcase
      end
      RQ_GETS, RQ_GETM: begin
        unique case (st) inside
          ST_S: begin
            shr = 1'b1;
            if (getm) st_next = ST_I;
          end
          ST_E: begin
            shr     = 1'b1;
            send    = 1'b1;
            st_next = getm ? ST_I : ST_F;
          end
          ST_O, ST_F: begin
            shr  = 1'b1;
            send = 1'b1;
            if (getm) st_next = ST_I;
          end
          ST_M: begin
            shr     = 1'b1;
            send    = 1'b1;
            st_next = getm ? ST_I : ST_O;
          end
          ST_SM: begin
            shr = 1'b1;
          end
          ST_OM: begin
            shr  = 1'b1;
            send = 1'b1;
            if (getm) st_next = ST_SM;
          end
          default: begin
          end
        endcase
      end
      RQ_DATA: begin
        unique case (st) inside
          ST_IM, ST_SM, ST_OM: begin
            to_proc = 1'b1;
            st_next = ST_M;
          end
          ST_IS: begin
            to_proc = 1'b1;
            st_next = req.shared_in ? ST_S : ST_E;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.addr_out       = (to_proc || send || (bus_req != BUS_NONE)) ?
                         (req.line_addr & ADDR_MASK) : 32'd0;
    rsp.data_to_proc   = to_proc;
    rsp.bus_request    = bus_req;
    rsp.bus_data_send  = send;
    rsp.data_dest      = send ? RID_WRAP[req.requester_id] : 4'd0;
    rsp.shared_assert  = shr;
    rsp.miss_pulse     = miss;
    rsp.silent_upgrade = silent;
    rsp.protocol_error = err;
    rsp.new_state      = st_next;
  end

endmodule

// ===== design/moesif_snoop_line_controller_unit.sv =====
// Path: a request accepted at the port moves through the input register, then the
// response register, where it waits for rsp_ready.
// Throughput: one request per cycle while rsp_ready holds; line state updates when a
// request enters the response register; the next sees it in the following cycle.
// Reset: synchronous active-high rst empties both register stages and puts the line in I.
module moesif_snoop_line_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  msl_pkg::msl_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output msl_pkg::msl_rsp_t rsp
);
  import msl_pkg::*;

  // Input stage: holds one request until the response register can take it.
  logic      s1_valid;
  msl_req_t  s1_req;

  // The single coherence state of the line.
  logic [3:0] line_state;

  // Combinational response for the request in the input stage.
  msl_rsp_t  rsp_next;

  // The request in the input stage moves on when the response register is free
  // or is being emptied in this cycle.
  logic      advance;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  msl_next_state u_next_state (
    .state (line_state),
    .req   (s1_req),
    .rsp   (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
  end

  // The state and the response register load together, so a valid response on the
  // port carries the state the line is in now.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= ST_I;
      rsp_valid  <= 1'b0;
    end else begin
      if (advance) begin
        line_state <= rsp_next.new_state;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    line_state <= ST_OM)
    else $error("line state holds an undefined code");

  a_rsp_matches_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.new_state == line_state))
    else $error("pending response disagrees with the line state");

  a_error_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.protocol_error) |->
      (!rsp.data_to_proc && rsp.bus_request == BUS_NONE && !rsp.bus_data_send &&
       !rsp.shared_assert && !rsp.miss_pulse && rsp.addr_out == 32'd0))
    else $error("protocol error response carries an action");

  a_send_implies_shared: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bus_data_send) |-> rsp.shared_assert)
    else $error("bus data driven without the shared line");

  a_state_moves_with_rsp: assert property (@(posedge clk) disable iff (rst)
    (line_state != $past(line_state)) |-> (rsp_valid && !$past(rst)) || $past(rst))
    else $error("line state changed without a response");
`endif

endmodule
